// ----- src/i2cbb_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cbb_pkg
// Types, codes and constants shared by the I2C bit-bang master files.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

    localparam logic [15:0] RESET_HALF_PERIOD = 16'd144;
    localparam logic [15:0] RESET_POLL_LIMIT  = 16'd250;
    localparam int          BITS_PER_BYTE     = 8;
    localparam logic [3:0]  LAST_BIT          = 4'(BITS_PER_BYTE);

    // configuration register indexes
    localparam logic CFG_IDX_HALF_PERIOD = 1'b0;
    localparam logic CFG_IDX_POLL_LIMIT  = 1'b1;

    typedef enum logic [2:0] {
        ACT_START    = 3'd0,
        ACT_STOP     = 3'd1,
        ACT_WRITE    = 3'd2,
        ACT_READ     = 3'd3,
        ACT_WAIT_ACK = 3'd4,
        ACT_LONE_ACK = 3'd5
    } t_action;

    typedef enum logic [4:0] {
        PH_IDLE       = 5'd0,
        PH_ST_REL     = 5'd1,
        PH_ST_SDA_LO  = 5'd2,
        PH_ST_SCL_LO  = 5'd3,
        PH_SP_SDA_LO  = 5'd4,
        PH_SP_SCL_HI  = 5'd5,
        PH_SP_SDA_HI  = 5'd6,
        PH_WR_DATA    = 5'd7,
        PH_WR_SCL_HI  = 5'd8,
        PH_RD_SCL_HI  = 5'd9,
        PH_RD_SCL_LO  = 5'd10,
        PH_AK_DATA    = 5'd11,
        PH_AK_SCL_HI  = 5'd12,
        PH_AK_SCL_LO  = 5'd13,
        PH_AK_REL     = 5'd14,
        PH_WA_REL     = 5'd15,
        PH_WA_SCL_HI  = 5'd16,
        PH_WA_POLL    = 5'd17,
        PH_TO_SDA_LO  = 5'd18,
        PH_TO_SCL_HI  = 5'd19,
        PH_TO_SDA_HI  = 5'd20,
        PH_WA_SCL_LO  = 5'd21
    } t_phase;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_cmd;

    typedef struct packed {
        logic       scl_out;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } t_res;

    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [15:0] ack_poll_limit;
    } t_cfg;

endpackage

// ----- src/i2cbb_chan_if.sv -----
// ----------------------------------------------------------------------------
// i2cbb_chan_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface i2cbb_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/i2cbb_seq.sv -----
// ----------------------------------------------------------------------------
// i2cbb_seq
// Bus sequencer: one tick per beat, state update and result in one pass.
// ----------------------------------------------------------------------------
module i2cbb_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  i2cbb_pkg::t_cmd i_cmd,
    input  i2cbb_pkg::t_cfg i_cfg,
    output i2cbb_pkg::t_res o_res
);
    import i2cbb_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_delay, n_delay;
    logic [3:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_poll, n_poll;
    logic        r_ack, n_ack;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic [7:0]  r_rx, n_rx;
    logic        r_fail, n_fail;

    logic        enter;
    logic        fin;
    logic        expire;
    logic [15:0] dec;
    logic [15:0] h_eff;
    logic [16:0] poll_inc;
    logic [3:0]  bit_inc;

    assign h_eff    = (i_cfg.half_period_ticks == 16'd0) ? 16'd1 : i_cfg.half_period_ticks;
    assign dec      = (r_delay != 16'd0) ? r_delay - 16'd1 : 16'd0;
    assign expire   = (dec == 16'd0);
    assign poll_inc = {1'b0, r_poll} + 17'd1;
    assign bit_inc  = r_bit + 4'd1;

    // next phase
    always_comb begin
        n_phase = r_phase;
        enter   = 1'b0;
        fin     = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_cmd.cmd_valid) begin
                    case (t_action'(i_cmd.action))
                        ACT_START:    begin enter = 1'b1; n_phase = PH_ST_REL;    end
                        ACT_STOP:     begin enter = 1'b1; n_phase = PH_SP_SDA_LO; end
                        ACT_WRITE:    begin enter = 1'b1; n_phase = PH_WR_DATA;   end
                        ACT_READ:     begin enter = 1'b1; n_phase = PH_RD_SCL_HI; end
                        ACT_WAIT_ACK: begin enter = 1'b1; n_phase = PH_WA_REL;    end
                        ACT_LONE_ACK: begin enter = 1'b1; n_phase = PH_AK_DATA;   end
                        default: ;
                    endcase
                end
            end
            PH_WA_POLL: begin
                if (!i_cmd.sda_in) begin
                    enter   = 1'b1;
                    n_phase = PH_WA_SCL_LO;
                end else if (poll_inc > {1'b0, i_cfg.ack_poll_limit}) begin
                    enter   = 1'b1;
                    n_phase = PH_TO_SDA_LO;
                end
            end
            default: begin
                if (expire) begin
                    priority case (r_phase)
                        PH_ST_REL:    begin enter = 1'b1; n_phase = PH_ST_SDA_LO; end
                        PH_ST_SDA_LO: begin enter = 1'b1; n_phase = PH_ST_SCL_LO; end
                        PH_SP_SDA_LO: begin enter = 1'b1; n_phase = PH_SP_SCL_HI; end
                        PH_SP_SCL_HI: begin enter = 1'b1; n_phase = PH_SP_SDA_HI; end
                        PH_WR_DATA:   begin enter = 1'b1; n_phase = PH_WR_SCL_HI; end
                        PH_WR_SCL_HI: begin
                            if (bit_inc >= LAST_BIT) begin
                                fin = 1'b1;
                            end else begin
                                enter   = 1'b1;
                                n_phase = PH_WR_DATA;
                            end
                        end
                        PH_RD_SCL_HI: begin enter = 1'b1; n_phase = PH_RD_SCL_LO; end
                        PH_RD_SCL_LO: begin
                            enter   = 1'b1;
                            n_phase = (r_bit >= LAST_BIT) ? PH_AK_DATA : PH_RD_SCL_HI;
                        end
                        PH_AK_DATA:   begin enter = 1'b1; n_phase = PH_AK_SCL_HI; end
                        PH_AK_SCL_HI: begin enter = 1'b1; n_phase = PH_AK_SCL_LO; end
                        PH_AK_SCL_LO: begin
                            if (r_ack) begin
                                enter   = 1'b1;
                                n_phase = PH_AK_REL;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        PH_WA_REL:    begin enter = 1'b1; n_phase = PH_WA_SCL_HI; end
                        PH_WA_SCL_HI: n_phase = PH_WA_POLL;
                        PH_TO_SDA_LO: begin enter = 1'b1; n_phase = PH_TO_SCL_HI; end
                        PH_TO_SCL_HI: begin enter = 1'b1; n_phase = PH_TO_SDA_HI; end
                        PH_TO_SDA_HI: begin enter = 1'b1; n_phase = PH_WA_SCL_LO; end
                        default:      fin = 1'b1;
                    endcase
                    if (fin) begin
                        n_phase = PH_IDLE;
                    end
                end
            end
        endcase
    end

    // datapath and line levels
    always_comb begin
        n_delay = r_delay;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_poll  = r_poll;
        n_ack   = r_ack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_rx    = r_rx;
        n_fail  = r_fail;

        if (r_phase == PH_IDLE) begin
            if (enter) begin
                n_ack  = i_cmd.send_ack;
                n_bit  = 4'd0;
                n_poll = 16'd0;
                if (t_action'(i_cmd.action) == ACT_WRITE) begin
                    n_shift = i_cmd.tx_byte;
                end else if (t_action'(i_cmd.action) == ACT_READ) begin
                    n_shift = 8'd0;
                end else if (t_action'(i_cmd.action) == ACT_WAIT_ACK) begin
                    n_fail = 1'b0;
                end
            end
        end else if (r_phase == PH_WA_POLL) begin
            if (i_cmd.sda_in) begin
                if (enter) begin
                    n_fail = 1'b1;
                end else begin
                    n_poll = poll_inc[15:0];
                end
            end
        end else begin
            n_delay = dec;
            if (expire && r_phase == PH_WR_SCL_HI) begin
                n_scl   = 1'b0;
                n_shift = {r_shift[6:0], 1'b0};
                n_bit   = bit_inc;
                if (fin) begin
                    n_sda = 1'b1;
                end
            end else if (expire && r_phase == PH_RD_SCL_HI) begin
                n_shift = {r_shift[6:0], i_cmd.sda_in};
                n_bit   = bit_inc;
                if (bit_inc >= LAST_BIT) begin
                    n_rx = {r_shift[6:0], i_cmd.sda_in};
                end
            end
        end

        if (enter) begin
            n_delay = h_eff;
            case (n_phase)
                PH_ST_REL:    begin n_sda = 1'b1; n_scl = 1'b1; end
                PH_ST_SDA_LO, PH_SP_SDA_LO, PH_TO_SDA_LO: n_sda = 1'b0;
                PH_ST_SCL_LO, PH_RD_SCL_LO, PH_AK_SCL_LO, PH_WA_SCL_LO: n_scl = 1'b0;
                PH_SP_SCL_HI, PH_WR_SCL_HI, PH_RD_SCL_HI, PH_AK_SCL_HI,
                PH_WA_SCL_HI, PH_TO_SCL_HI: n_scl = 1'b1;
                PH_SP_SDA_HI, PH_AK_REL, PH_WA_REL, PH_TO_SDA_HI: n_sda = 1'b1;
                PH_WR_DATA:   n_sda = n_shift[7];
                PH_AK_DATA:   n_sda = ~n_ack;
                default: ;
            endcase
        end else if (fin) begin
            n_delay = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_delay <= 16'd0;
            r_bit   <= 4'd0;
            r_shift <= 8'd0;
            r_poll  <= 16'd0;
            r_ack   <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_rx    <= 8'd0;
            r_fail  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_delay <= n_delay;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_poll  <= n_poll;
            r_ack   <= n_ack;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_rx    <= n_rx;
            r_fail  <= n_fail;
        end
    end

    always_comb begin
        o_res.scl_out     = n_scl;
        o_res.sda_release = n_sda;
        o_res.busy_res    = (n_phase != PH_IDLE);
        o_res.done_res    = fin;
        o_res.rx_byte     = n_rx;
        o_res.ack_failed  = n_fail;
    end

endmodule

// ----- src/i2cbb_obuf.sv -----
// ----------------------------------------------------------------------------
// i2cbb_obuf
// Two-entry result queue: output register plus skid entry.
// ----------------------------------------------------------------------------
module i2cbb_obuf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  i2cbb_pkg::t_res i_data,
    output logic            o_space,
    output logic            o_valid,
    input  logic            i_pop,
    output i2cbb_pkg::t_res o_data
);
    import i2cbb_pkg::*;

    logic [1:0] r_cnt;
    t_res       r_e0, r_e1;

    assign o_space = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_e0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            unique case ({i_push, i_pop})
                2'b10: r_cnt <= r_cnt + 2'd1;
                2'b01: r_cnt <= r_cnt - 2'd1;
                2'b11, 2'b00: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case ({i_push, i_pop})
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    r_e0 <= i_data;
                end else begin
                    r_e1 <= i_data;
                end
            end
            2'b01: r_e0 <= r_e1;
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    r_e0 <= i_data;
                end else begin
                    r_e0 <= r_e1;
                    r_e1 <= i_data;
                end
            end
            2'b00: ;
        endcase
    end

endmodule

// ----- src/i2c_bitbang_master_top.sv -----
// ----------------------------------------------------------------------------
// i2c_bitbang_master_top
// I2C bit-bang master: one bus tick per input beat, one status beat per tick.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one tick: sampled SDA plus an optional command (START, STOP,
//   write byte, read byte with ACK/NACK, wait for ACK, lone ACK/NACK). A
//   command offered while busy, or an unknown action code, is ignored.
//   o_res returns one beat per tick: SCL level, SDA release, busy, done,
//   last received byte and ack-failure flag, as they stand after that tick.
//   Each line setting holds for half_period_ticks ticks (0 acts as 1).
//   Each accepted tick's result beat is registered in the output queue.
//   Throughput: one tick per cycle; the sequencer updates all state in one
//   pass from its registers, so ticks follow back to back.
//   A two-entry result queue sits on the output: while the receiver stalls
//   ticks are taken until both entries hold a beat, then i_cmd.ready drops
//   until a beat is drained.
//   Configuration: i_cfg_we with i_cfg_idx 0 (half period) or 1 (ack poll
//   limit), written while no tick is outstanding.
//   Reset: bus idle (SCL and SDA released), queue empty, registers at
//   their defaults of 144 and 250.
// ----------------------------------------------------------------------------
module i2c_bitbang_master_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cbb_chan_if.sink   i_cmd,
    i2cbb_chan_if.source o_res,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import i2cbb_pkg::*;

    t_cfg r_cfg;
    t_res seq_res;
    logic step;
    logic space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks <= RESET_HALF_PERIOD;
            r_cfg.ack_poll_limit    <= RESET_POLL_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_HALF_PERIOD: r_cfg.half_period_ticks <= i_cfg_data;
                CFG_IDX_POLL_LIMIT:  r_cfg.ack_poll_limit    <= i_cfg_data;
            endcase
        end
    end

    assign i_cmd.ready = space;
    assign step        = i_cmd.valid & space;

    i2cbb_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_cmd   (i_cmd.data),
        .i_cfg   (r_cfg),
        .o_res   (seq_res)
    );

    i2cbb_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_data  (seq_res),
        .o_space (space),
        .o_valid (o_res.valid),
        .i_pop   (o_res.valid & o_res.ready),
        .o_data  (o_res.data)
    );

endmodule

// ----- src/i2cbb_chk.sv -----
// ----------------------------------------------------------------------------
// i2cbb_chk
// Port-level checks for the I2C bit-bang master, bound to the top level.
// ----------------------------------------------------------------------------
module i2cbb_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_cmd_valid,
    input logic            i_cmd_ready,
    input logic            i_res_valid,
    input logic            i_res_ready,
    input i2cbb_pkg::t_res i_res_data
);
    import i2cbb_pkg::*;

    // stalled beat stays offered
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result beat dropped while stalled");

    // done tick never reports busy
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !(i_res_data.done_res && i_res_data.busy_res))
        else $error("done and busy together");

    // back-pressure only when results are queued
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd_ready |-> i_res_valid)
        else $error("input stalled with empty output");

    // accepted tick yields a result next cycle
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> i_res_valid)
        else $error("accepted tick gave no result");

endmodule

bind i2c_bitbang_master_top i2cbb_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the I2C bit-bang master. Every accepted tick is run through a
// local model of the bus sequencer, and every status beat is compared against
// its prediction, or against the stated status for typed table rows. A short
// table of directed commands comes first. Random bus transfers follow under
// several half-period and ack-poll settings. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cbb_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SEND_GAP_PCT = 19;
    localparam int RECV_STALL_PCT = 19;
    localparam int FIRST_BUS_ROW = 3;

    // action codes the block must ignore
    localparam logic [2:0] ACT_UNUSED_A = 3'd6;
    localparam logic [2:0] ACT_UNUSED_B = 3'd7;

    localparam t_res IDLE_STATUS = '{scl_out: 1'b1, sda_release: 1'b1, busy_res: 1'b0,
                                     done_res: 1'b0, rx_byte: 8'h00, ack_failed: 1'b0};
    localparam t_res START_STATUS = '{scl_out: 1'b1, sda_release: 1'b1, busy_res: 1'b1,
                                      done_res: 1'b0, rx_byte: 8'h00, ack_failed: 1'b0};

    // SDA level offered on the ticks that follow a command
    typedef enum logic [1:0] {
        FILL_LOW,
        FILL_HIGH,
        FILL_RAND
    } t_sda_fill;

    typedef struct {
        t_cmd      cmd;
        t_sda_fill fill;
        bit        noisy;    // offer commands while busy
        bit        typed;
        t_res      want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_data;

    i2cbb_chan_if #(.T(t_cmd)) cmd_if ();
    i2cbb_chan_if #(.T(t_res)) res_if ();

    i2c_bitbang_master_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // sequencer model state
    t_cfg        m_cfg;
    t_phase      m_phase;
    logic [15:0] m_hold;
    logic [3:0]  m_bits;
    logic [7:0]  m_shift;
    logic [15:0] m_polls;
    logic        m_ack_sel;
    logic        m_scl;
    logic        m_sda;
    logic [7:0]  m_rx;
    logic        m_fail;
    logic        m_done;

    t_res status_q [$];
    t_res status_want;
    int   mismatches;
    int   quiet_cycles;
    int   cmds_sent;
    bit   no_gaps;

    t_dir_row dir_rows [0:16] = '{
        '{{1'b0, ACT_START,    8'h00, 1'b0, 1'b1}, FILL_RAND, 1'b0, 1'b1, IDLE_STATUS},
        '{{1'b1, ACT_UNUSED_A, 8'hFF, 1'b1, 1'b1}, FILL_RAND, 1'b0, 1'b1, IDLE_STATUS},
        '{{1'b1, ACT_UNUSED_B, 8'h00, 1'b0, 1'b0}, FILL_RAND, 1'b0, 1'b1, IDLE_STATUS},
        '{{1'b1, ACT_START,    8'h00, 1'b0, 1'b1}, FILL_RAND, 1'b0, 1'b1, START_STATUS},
        '{{1'b1, ACT_WRITE,    8'hFF, 1'b0, 1'b1}, FILL_RAND, 1'b0, 1'b0, IDLE_STATUS},
        '{{1'b1, ACT_WAIT_ACK, 8'h00, 1'b0, 1'b1}, FILL_LOW,  1'b0, 1'b0, IDLE_STATUS},
        '{{1'b1, ACT_WRITE,    8'h00, 1'b1, 1'b0}, FILL_RAND, 1'b0, 1'b0, IDLE_STATUS},
        '{{1'b1, ACT_WAIT_ACK, 8'h00, 1'b0, 1'b1}, FILL_HIGH, 1'b0, 1'b0, IDLE_STATUS},
        '{{1'b1, ACT_READ,     8'h00, 1'b1, 1'b1}, FILL_HIGH, 1'b0, 1'b0, IDLE_STATUS},
        '{{1'b1, ACT_READ,     8'h00, 1'b0, 1'b0}, FILL_LOW,  1'b0, 1'b0, IDLE_STATUS},
        '{{1'b1, ACT_READ,     8'h3C, 1'b1, 1'b1}, FILL_RAND, 1'b0, 1'b0, IDLE_STATUS},
        '{{1'b1, ACT_LONE_ACK, 8'h00, 1'b1, 1'b1}, FILL_RAND, 1'b0, 1'b0, IDLE_STATUS},
        '{{1'b1, ACT_LONE_ACK, 8'h00, 1'b0, 1'b1}, FILL_RAND, 1'b0, 1'b0, IDLE_STATUS},
        '{{1'b1, ACT_WRITE,    8'hA5, 1'b0, 1'b1}, FILL_RAND, 1'b1, 1'b0, IDLE_STATUS},
        '{{1'b1, ACT_WAIT_ACK, 8'h00, 1'b1, 1'b1}, FILL_RAND, 1'b1, 1'b0, IDLE_STATUS},
        '{{1'b1, ACT_READ,     8'h00, 1'b0, 1'b1}, FILL_RAND, 1'b1, 1'b0, IDLE_STATUS},
        '{{1'b1, ACT_STOP,     8'h00, 1'b0, 1'b1}, FILL_RAND, 1'b0, 1'b0, IDLE_STATUS}
    };

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------- sequencer model ----------------

    function automatic void bus_enter(t_phase p);
        m_phase = p;
        m_hold  = (m_cfg.half_period_ticks == 16'd0) ? 16'd1 : m_cfg.half_period_ticks;
        case (p)
            PH_ST_REL: begin
                m_sda = 1'b1;
                m_scl = 1'b1;
            end
            PH_ST_SDA_LO, PH_SP_SDA_LO, PH_TO_SDA_LO:               m_sda = 1'b0;
            PH_ST_SCL_LO, PH_RD_SCL_LO, PH_AK_SCL_LO, PH_WA_SCL_LO: m_scl = 1'b0;
            PH_SP_SCL_HI, PH_WR_SCL_HI, PH_RD_SCL_HI, PH_AK_SCL_HI,
            PH_WA_SCL_HI, PH_TO_SCL_HI:                             m_scl = 1'b1;
            PH_SP_SDA_HI, PH_AK_REL, PH_WA_REL, PH_TO_SDA_HI:       m_sda = 1'b1;
            PH_WR_DATA:                                             m_sda = m_shift[7];
            PH_AK_DATA:                                             m_sda = !m_ack_sel;
            default: ;
        endcase
    endfunction

    function automatic void bus_finish();
        m_phase = PH_IDLE;
        m_hold  = 16'd0;
        m_done  = 1'b1;
    endfunction

    function automatic void bus_hold_over(logic sda);
        case (m_phase)
            PH_ST_REL:    bus_enter(PH_ST_SDA_LO);
            PH_ST_SDA_LO: bus_enter(PH_ST_SCL_LO);
            PH_SP_SDA_LO: bus_enter(PH_SP_SCL_HI);
            PH_SP_SCL_HI: bus_enter(PH_SP_SDA_HI);
            PH_WR_DATA:   bus_enter(PH_WR_SCL_HI);
            PH_WR_SCL_HI: begin
                m_scl   = 1'b0;
                m_shift = m_shift << 1;
                m_bits  = m_bits + 4'd1;
                if (m_bits >= LAST_BIT) begin
                    // last data bit: release SDA on the done tick, no extra hold
                    m_sda = 1'b1;
                    bus_finish();
                end else begin
                    bus_enter(PH_WR_DATA);
                end
            end
            PH_RD_SCL_HI: begin
                m_shift = {m_shift[6:0], sda};
                m_bits  = m_bits + 4'd1;
                if (m_bits >= LAST_BIT)
                    m_rx = m_shift;
                bus_enter(PH_RD_SCL_LO);
            end
            PH_RD_SCL_LO: begin
                if (m_bits >= LAST_BIT)
                    bus_enter(PH_AK_DATA);
                else
                    bus_enter(PH_RD_SCL_HI);
            end
            PH_AK_DATA:   bus_enter(PH_AK_SCL_HI);
            PH_AK_SCL_HI: bus_enter(PH_AK_SCL_LO);
            PH_AK_SCL_LO: begin
                if (m_ack_sel)
                    bus_enter(PH_AK_REL);
                else
                    bus_finish();
            end
            PH_WA_REL:    bus_enter(PH_WA_SCL_HI);
            PH_WA_SCL_HI: begin
                m_phase = PH_WA_POLL;
                m_hold  = 16'd0;
            end
            PH_TO_SDA_LO: bus_enter(PH_TO_SCL_HI);
            PH_TO_SCL_HI: bus_enter(PH_TO_SDA_HI);
            PH_TO_SDA_HI: bus_enter(PH_WA_SCL_LO);
            default:      bus_finish();
        endcase
    endfunction

    function automatic t_res i2c_tick_predict(t_cmd c);
        logic [16:0] next_poll;
        m_done = 1'b0;
        if (m_phase == PH_IDLE) begin
            if (c.cmd_valid && c.action <= ACT_LONE_ACK) begin
                m_ack_sel = c.send_ack;
                m_bits    = 4'd0;
                m_polls   = 16'd0;
                case (c.action)
                    ACT_START: bus_enter(PH_ST_REL);
                    ACT_STOP:  bus_enter(PH_SP_SDA_LO);
                    ACT_WRITE: begin
                        m_shift = c.tx_byte;
                        bus_enter(PH_WR_DATA);
                    end
                    ACT_READ: begin
                        m_shift = 8'h00;
                        bus_enter(PH_RD_SCL_HI);
                    end
                    ACT_WAIT_ACK: begin
                        m_fail = 1'b0;
                        bus_enter(PH_WA_REL);
                    end
                    default: bus_enter(PH_AK_DATA);
                endcase
            end
        end else if (m_phase == PH_WA_POLL) begin
            if (!c.sda_in) begin
                bus_enter(PH_WA_SCL_LO);
            end else begin
                next_poll = {1'b0, m_polls} + 17'd1;
                if (next_poll > {1'b0, m_cfg.ack_poll_limit}) begin
                    m_fail = 1'b1;
                    bus_enter(PH_TO_SDA_LO);
                end else begin
                    m_polls = next_poll[15:0];
                end
            end
        end else begin
            if (m_hold > 16'd0)
                m_hold = m_hold - 16'd1;
            if (m_hold == 16'd0)
                bus_hold_over(c.sda_in);
        end
        return '{scl_out: m_scl, sda_release: m_sda, busy_res: (m_phase != PH_IDLE),
                 done_res: m_done, rx_byte: m_rx, ack_failed: m_fail};
    endfunction

    // ---------------- stimulus ----------------

    function automatic t_cmd bus_cmd(logic [2:0] act);
        t_cmd c;
        c.cmd_valid = 1'b1;
        c.action    = act;
        c.tx_byte   = 8'($urandom);
        c.send_ack  = 1'($urandom);
        c.sda_in    = 1'($urandom);
        return c;
    endfunction

    function automatic t_cmd filler_tick(t_sda_fill fill, bit noisy);
        t_cmd c;
        c = bus_cmd(3'($urandom_range(7)));
        c.cmd_valid = noisy && ($urandom_range(1) == 1);
        case (fill)
            FILL_LOW:  c.sda_in = 1'b0;
            FILL_HIGH: c.sda_in = 1'b1;
            default: ;
        endcase
        return c;
    endfunction

    function automatic t_sda_fill pick_fill();
        case ($urandom_range(2))
            0:       return FILL_LOW;
            // steady high only where the ack wait times out soon
            1:       return (m_cfg.ack_poll_limit < 16'd16) ? FILL_HIGH : FILL_RAND;
            default: return FILL_RAND;
        endcase
    endfunction

    task automatic drive_tick(t_cmd c, bit typed, t_res want);
        t_res predicted;
        while (!no_gaps && $urandom_range(99) < SEND_GAP_PCT) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= c;
        do @(posedge i_clk); while (!cmd_if.ready);
        predicted = i2c_tick_predict(c);
        status_q.push_back(typed ? want : predicted);
    endtask

    // one command beat, then filler ticks until the sequencer is idle again
    task automatic run_command(t_cmd c, t_sda_fill fill, bit noisy, bit typed, t_res want);
        drive_tick(c, typed, want);
        while (m_phase != PH_IDLE)
            drive_tick(filler_tick(fill, noisy), 1'b0, IDLE_STATUS);
        cmds_sent++;
    endtask

    task automatic run_rand(logic [2:0] act);
        run_command(bus_cmd(act), pick_fill(), $urandom_range(99) < 25, 1'b0, IDLE_STATUS);
    endtask

    task automatic pause_sender();
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (status_q.size() != 0);
    endtask

    task automatic apply_settings(logic [15:0] half, logic [15:0] limit);
        pause_sender();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_HALF_PERIOD;
        i_cfg_data <= half;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_IDX_POLL_LIMIT;
        i_cfg_data <= limit;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        m_cfg = '{half_period_ticks: half, ack_poll_limit: limit};
    endtask

    // mostly well-formed transfers with random content, some stray commands
    task automatic random_transfers(int n_cmds);
        int stop_at;
        stop_at = cmds_sent + n_cmds;
        while (cmds_sent < stop_at) begin
            if ($urandom_range(99) < 3)
                pause_sender();
            if ($urandom_range(99) < 10)
                drive_tick(filler_tick(FILL_RAND, 1'b0), 1'b0, IDLE_STATUS);
            if ($urandom_range(99) < 80) begin
                run_rand(ACT_START);
                run_rand(ACT_WRITE);
                run_rand(ACT_WAIT_ACK);
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(1) == 1) begin
                        run_rand(ACT_WRITE);
                        run_rand(ACT_WAIT_ACK);
                    end else begin
                        run_rand(ACT_READ);
                    end
                end
                run_rand(ACT_STOP);
            end else begin
                run_rand(3'($urandom_range(7)));
            end
        end
    endtask

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_IDX_HALF_PERIOD;
        i_cfg_data   = 16'd0;
        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        res_if.ready = 1'b0;
        mismatches   = 0;
        quiet_cycles = 0;
        cmds_sent    = 0;
        no_gaps      = 1'b0;

        m_cfg     = '{half_period_ticks: RESET_HALF_PERIOD, ack_poll_limit: RESET_POLL_LIMIT};
        m_phase   = PH_IDLE;
        m_hold    = 16'd0;
        m_bits    = 4'd0;
        m_shift   = 8'h00;
        m_polls   = 16'd0;
        m_ack_sel = 1'b0;
        m_scl     = 1'b1;
        m_sda     = 1'b1;
        m_rx      = 8'h00;
        m_fail    = 1'b0;
        m_done    = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            // zero half period behaves as one
            if (i == FIRST_BUS_ROW)
                apply_settings(16'd0, 16'd2);
            run_command(dir_rows[i].cmd, dir_rows[i].fill, dir_rows[i].noisy,
                        dir_rows[i].typed, dir_rows[i].want);
        end

        apply_settings(16'd1, 16'd0);
        random_transfers(10);

        apply_settings(16'd2, 16'd3);
        no_gaps = 1'b1;
        random_transfers(5);
        no_gaps = 1'b0;

        apply_settings(16'd3, 16'd1);
        random_transfers(2);

        // widest poll limit: the wait ends on a low SDA poll
        apply_settings(16'd1, 16'hFFFF);
        run_command(bus_cmd(ACT_WAIT_ACK), FILL_RAND, 1'b0, 1'b0, IDLE_STATUS);
        random_transfers(4);

        pause_sender();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // ---------------- status checking ----------------

    task automatic cmp_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (status_q.size() == 0) begin
                $display("%0t ns: status beat with nothing expected, got %p",
                         $time, res_if.data);
                mismatches++;
            end else begin
                status_want = status_q.pop_front();
                cmp_field("scl_out", 8'(status_want.scl_out), 8'(res_if.data.scl_out));
                cmp_field("sda_release", 8'(status_want.sda_release),
                          8'(res_if.data.sda_release));
                cmp_field("busy_res", 8'(status_want.busy_res), 8'(res_if.data.busy_res));
                cmp_field("done_res", 8'(status_want.done_res), 8'(res_if.data.done_res));
                cmp_field("rx_byte",     status_want.rx_byte,     res_if.data.rx_byte);
                cmp_field("ack_failed", 8'(status_want.ack_failed),
                          8'(res_if.data.ack_failed));
            end
        end
        res_if.ready <= no_gaps || ($urandom_range(99) >= RECV_STALL_PCT);
    end

    // watchdog: no beat moving on either channel for too long
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule

// ----- i2c_bitbang_master_top.f -----
src/i2cbb_pkg.sv
src/i2cbb_chan_if.sv
src/i2cbb_seq.sv
src/i2cbb_obuf.sv
src/i2c_bitbang_master_top.sv
src/i2cbb_chk.sv
verif/tb_top.sv
